/* sv/gte_pkg.sv */
// ----------------------------------------------------------------------------
// gte_pkg: shared types and constants for the glob trigram extractor
// Parse mode codes, pattern metacharacters and the per-byte step record.
// ----------------------------------------------------------------------------
package gte_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL,
    MODE_ESCAPE,
    MODE_CLASS_OPEN,
    MODE_CLASS_BANG,
    MODE_CLASS_BODY
  } gte_mode_t;

  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_QUEST     = 8'h3F;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_BANG      = 8'h21;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;

  // Parser state after one byte, plus what that byte yields.
  typedef struct packed {
    gte_mode_t   mode;
    logic [7:0]  win0;
    logic [7:0]  win1;
    logic [1:0]  count;
    logic [23:0] tri_val;
    logic        got;
    logic        last;
    logic        emit;
  } gte_step_t;

endpackage

/* sv/glob_trigram_extractor.sv */
// ----------------------------------------------------------------------------
// glob_trigram_extractor: trigram extraction from a glob search pattern
// Takes one pattern byte per transfer and delivers each completed literal
// trigram, plus a final result flagged pattern_done at the end of a pattern.
// ----------------------------------------------------------------------------
// A result is registered and valid in the cycle after the byte that causes it.
// Throughput: one byte per cycle; the parser state update is a single short
// combinational step between the state registers and the result register.
// A byte is held back only while a result waits and the sink stalls.
// Reset (rst, synchronous): normal mode, empty window, no result pending.
module glob_trigram_extractor (
  input  logic        clk,
  input  logic        rst,
  // pattern byte channel
  input  logic        pattern_valid,
  output logic        pattern_stall,
  input  logic [7:0]  pattern_byte,
  input  logic        end_of_pattern,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic [23:0] trigram,
  output logic        has_trigram,
  output logic        pattern_done
);
  import gte_pkg::*;

  // Parser state: current mode and the two most recent literals.
  gte_mode_t  mode;
  logic [7:0] win0;
  logic [7:0] win1;
  logic [1:0] window_count;

  gte_step_t  step;
  logic       pattern_accept;

  // Hold the input only when the result register is full and not drained.
  assign pattern_stall  = result_valid & result_stall;
  assign pattern_accept = pattern_valid & ~pattern_stall;

  gte_parse u_parse (
    .mode           (mode),
    .win0           (win0),
    .win1           (win1),
    .count          (window_count),
    .pattern_byte   (pattern_byte),
    .end_of_pattern (end_of_pattern),
    .step           (step)
  );

  // Advance the parser state on every accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_NORMAL;
      win0         <= '0;
      win1         <= '0;
      window_count <= '0;
    end else if (pattern_accept) begin
      mode         <= step.mode;
      win0         <= step.win0;
      win1         <= step.win1;
      window_count <= step.count;
    end
  end

  // Result register: load when a byte yields a result, drop the valid once
  // the sink takes it. A byte yielding nothing leaves the register alone
  // unless its previous contents have just been transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pattern_accept && step.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pattern_accept && step.emit) begin
      trigram      <= step.got ? step.tri_val : 24'd0;
      has_trigram  <= step.got;
      pattern_done <= step.last;
    end
  end

`ifndef NO_ASSERTIONS
  // The window never claims more than two pending literals.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    window_count != 2'd3)
    else $error("window count out of range");

  // A final byte leaves the parser in its reset state.
  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    pattern_accept && end_of_pattern |=>
      mode == MODE_NORMAL && window_count == 2'd0 && win0 == 8'd0 && win1 == 8'd0)
    else $error("state not cleared after final byte");

  // A final byte always produces a pattern_done result.
  a_final_result: assert property (@(posedge clk) disable iff (rst)
    pattern_accept && end_of_pattern |=> result_valid && pattern_done)
    else $error("final byte gave no pattern_done result");

  // A result without a trigram is only ever the end-of-pattern marker.
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    result_valid && !has_trigram |-> pattern_done && trigram == 24'd0)
    else $error("empty result without pattern_done");
`endif

endmodule

/* sv/gte_parse.sv */
// ----------------------------------------------------------------------------
// gte_parse: next-state logic for one pattern byte
// Mode update, literal window shift and trigram assembly, all combinational.
// ----------------------------------------------------------------------------
module gte_parse (
  input  gte_pkg::gte_mode_t mode,
  input  logic [7:0]         win0,
  input  logic [7:0]         win1,
  input  logic [1:0]         count,
  input  logic [7:0]         pattern_byte,
  input  logic               end_of_pattern,
  output gte_pkg::gte_step_t step
);
  import gte_pkg::*;

  logic push;
  logic clear;

  always_comb begin
    step         = '0;
    step.mode    = mode;
    step.win0    = win0;
    step.win1    = win1;
    step.count   = count;
    push         = 1'b0;
    clear        = 1'b0;

    case (mode)
      MODE_ESCAPE: begin
        step.mode = MODE_NORMAL;
        push      = 1'b1;
      end
      MODE_CLASS_OPEN: begin
        step.mode = (pattern_byte == CH_BANG) ? MODE_CLASS_BANG : MODE_CLASS_BODY;
      end
      MODE_CLASS_BANG: begin
        step.mode = MODE_CLASS_BODY;
      end
      MODE_CLASS_BODY: begin
        if (pattern_byte == CH_RBRACKET) begin
          step.mode = MODE_NORMAL;
          clear     = 1'b1;
        end
      end
      default: begin
        step.mode = MODE_NORMAL;
        if (pattern_byte == CH_BACKSLASH) begin
          step.mode = MODE_ESCAPE;
        end else if (pattern_byte inside {CH_STAR, CH_QUEST}) begin
          clear = 1'b1;
        end else if (pattern_byte == CH_LBRACKET) begin
          step.mode = MODE_CLASS_OPEN;
        end else begin
          push = 1'b1;
        end
      end
    endcase

    if (clear) begin
      step.win0  = '0;
      step.win1  = '0;
      step.count = '0;
    end

    // Shift the literal in; a full window completes a trigram.
    if (push) begin
      if (count[1]) begin
        step.tri_val = {pattern_byte, win1, win0};
        step.got     = 1'b1;
        step.win0    = win1;
        step.win1    = pattern_byte;
        step.count   = 2'd2;
      end else begin
        if (count[0]) begin
          step.win1 = pattern_byte;
        end else begin
          step.win0 = pattern_byte;
        end
        step.count = count + 2'd1;
      end
    end

    // Final byte: start afresh for the next pattern.
    if (end_of_pattern) begin
      step.mode  = MODE_NORMAL;
      step.win0  = '0;
      step.win1  = '0;
      step.count = '0;
    end

    step.last = end_of_pattern;
    step.emit = step.got | end_of_pattern;
  end

endmodule
